// File: rtl/mrt_pkg.sv
// Shared types and constants for the 4x4 matrix row transform.
// Holds the request and result payload structs and the fixed field widths.
// No dependencies.
package mrt_pkg;

  localparam int ELEM_FIELD_W = 32;
  localparam int FRAC_BITS    = 16;
  localparam int NUM_REGS     = 8;
  localparam int REG_IDX_W    = 3;
  localparam int REG_DATA_W   = 64;
  localparam int NUM_COLS     = 4;

  typedef struct packed {
    logic signed [ELEM_FIELD_W-1:0] left_0;
    logic signed [ELEM_FIELD_W-1:0] left_1;
    logic signed [ELEM_FIELD_W-1:0] left_2;
    logic signed [ELEM_FIELD_W-1:0] left_3;
  } left_row_t;

  typedef struct packed {
    logic signed [ELEM_FIELD_W-1:0] out_0;
    logic signed [ELEM_FIELD_W-1:0] out_1;
    logic signed [ELEM_FIELD_W-1:0] out_2;
    logic signed [ELEM_FIELD_W-1:0] out_3;
    logic                           saturated;
  } result_row_t;

  typedef logic [NUM_REGS-1:0][REG_DATA_W-1:0] right_regs_t;

endpackage

// File: rtl/mrt_mul_stage.sv
// First pipeline stage: sixteen element products of the left row and right matrix.
// Depends on mrt_pkg for the request struct and register file layout.
module mrt_mul_stage #(
  parameter int ELEM_WIDTH = 32,
  localparam int PW = 2 * ELEM_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mrt_pkg::left_row_t                in_data,
  input  mrt_pkg::right_regs_t              right_regs,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [3:0][3:0][PW-1:0]           prod
);

  logic signed [ELEM_WIDTH-1:0] a [4];
  logic [3:0][3:0][PW-1:0]      prod_next;
  logic                         load;

  assign a[0] = in_data.left_0[ELEM_WIDTH-1:0];
  assign a[1] = in_data.left_1[ELEM_WIDTH-1:0];
  assign a[2] = in_data.left_2[ELEM_WIDTH-1:0];
  assign a[3] = in_data.left_3[ELEM_WIDTH-1:0];

  for (genvar k = 0; k < 4; k++) begin : g_row
    for (genvar j = 0; j < 4; j++) begin : g_col
      logic signed [ELEM_WIDTH-1:0] b;
      logic signed [PW-1:0]         p;
      assign b = right_regs[k*2 + j/2][(j%2)*mrt_pkg::ELEM_FIELD_W +: ELEM_WIDTH];
      assign p = a[k] * b;
      assign prod_next[k][j] = p;
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_next;
    end
  end

endmodule

// File: rtl/mrt_sum_stage.sv
// Second and third pipeline stages: exact column sums of four products as a
// two-level registered adder tree. Depends on mrt_pkg for the column count.
module mrt_sum_stage #(
  parameter int ELEM_WIDTH = 32,
  localparam int PW = 2 * ELEM_WIDTH,
  localparam int SW = PW + 2
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [3:0][3:0][PW-1:0]                prod,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [mrt_pkg::NUM_COLS-1:0][SW-1:0]   sums
);

  logic                                        half_valid;
  logic                                        half_ready;
  logic [mrt_pkg::NUM_COLS-1:0][1:0][PW:0]     half;
  logic [mrt_pkg::NUM_COLS-1:0][1:0][PW:0]     half_next;
  logic [mrt_pkg::NUM_COLS-1:0][SW-1:0]        sums_next;

  for (genvar j = 0; j < mrt_pkg::NUM_COLS; j++) begin : g_col
    logic signed [PW:0]   h0;
    logic signed [PW:0]   h1;
    logic signed [SW-1:0] s;
    assign h0 = $signed(prod[0][j]) + $signed(prod[1][j]);
    assign h1 = $signed(prod[2][j]) + $signed(prod[3][j]);
    assign half_next[j][0] = h0;
    assign half_next[j][1] = h1;
    assign s = $signed(half[j][0]) + $signed(half[j][1]);
    assign sums_next[j] = s;
  end

  assign half_ready = !out_valid || out_ready;
  assign in_ready   = !half_valid || half_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        half_valid <= in_valid;
      end
      if (half_ready) begin
        out_valid <= half_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      half <= half_next;
    end
    if (half_valid && half_ready) begin
      sums <= sums_next;
    end
  end

endmodule

// File: rtl/mrt_sat_stage.sv
// Last pipeline stage: drop the fraction bits, clip each column to the element
// range and register the result row. Depends on mrt_pkg for the result struct.
module mrt_sat_stage #(
  parameter int ELEM_WIDTH = 32,
  localparam int SW = 2 * ELEM_WIDTH + 2
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [mrt_pkg::NUM_COLS-1:0][SW-1:0]   sums,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output mrt_pkg::result_row_t                   out_data
);

  localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (ELEM_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -(SW'(1) <<< (ELEM_WIDTH - 1));

  logic signed [ELEM_WIDTH-1:0]      res [mrt_pkg::NUM_COLS];
  logic [mrt_pkg::NUM_COLS-1:0]      clip;
  mrt_pkg::result_row_t              out_next;

  for (genvar j = 0; j < mrt_pkg::NUM_COLS; j++) begin : g_col
    logic signed [SW-1:0] q;
    assign q = $signed(sums[j]) >>> mrt_pkg::FRAC_BITS;
    always_comb begin
      if (q > MAXV) begin
        res[j]  = MAXV[ELEM_WIDTH-1:0];
        clip[j] = 1'b1;
      end else if (q < MINV) begin
        res[j]  = MINV[ELEM_WIDTH-1:0];
        clip[j] = 1'b1;
      end else begin
        res[j]  = q[ELEM_WIDTH-1:0];
        clip[j] = 1'b0;
      end
    end
  end

  always_comb begin
    out_next.out_0     = mrt_pkg::ELEM_FIELD_W'(res[0]);
    out_next.out_1     = mrt_pkg::ELEM_FIELD_W'(res[1]);
    out_next.out_2     = mrt_pkg::ELEM_FIELD_W'(res[2]);
    out_next.out_3     = mrt_pkg::ELEM_FIELD_W'(res[3]);
    out_next.saturated = |clip;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= out_next;
    end
  end

endmodule

// File: rtl/matrix4_row_transform_top.sv
// Top level of the 4x4 matrix row transform: right matrix registers and the
// four-stage multiply, sum and clip pipeline. Depends on mrt_pkg and the mrt_* stages.
//
//   channel  | signals                        | direction | moves
//   ---------+--------------------------------+-----------+--------------------------
//   in       | in_valid, in_ready, in_data    | in        | one left row per request
//   out      | out_valid, out_ready, out_data | out       | one result row per request
//   config   | wr_en, wr_index, wr_data       | in        | one right matrix register
//
// Registered in order: product registers, two adder tree levels, clip register.
// One request enters per cycle while no stage is stalled; the sixteen parallel multipliers set that rate.
// Each stage holds while the stage after it is full and stalled; bubbles close up.
// Reset clears all stage valid bits and the right matrix registers to zero.
module matrix4_row_transform_top #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mrt_pkg::left_row_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mrt_pkg::result_row_t             out_data,
  input  logic                             wr_en,
  input  logic [mrt_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [mrt_pkg::REG_DATA_W-1:0]   wr_data
);

  localparam int PW = 2 * ELEM_WIDTH;
  localparam int SW = PW + 2;

  mrt_pkg::right_regs_t                          right_regs;
  logic                                          mul_valid;
  logic                                          mul_ready;
  logic [3:0][3:0][PW-1:0]                       prod;
  logic                                          sum_valid;
  logic                                          sum_ready;
  logic [mrt_pkg::NUM_COLS-1:0][SW-1:0]          sums;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_regs <= '0;
    end else if (wr_en) begin
      right_regs[wr_index] <= wr_data;
    end
  end

  mrt_mul_stage #(.ELEM_WIDTH(ELEM_WIDTH)) u_mul (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .right_regs (right_regs),
    .out_valid  (mul_valid),
    .out_ready  (mul_ready),
    .prod       (prod)
  );

  mrt_sum_stage #(.ELEM_WIDTH(ELEM_WIDTH)) u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .prod      (prod),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .sums      (sums)
  );

  mrt_sat_stage #(.ELEM_WIDTH(ELEM_WIDTH)) u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .sums      (sums),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pipeline empty at output but request refused");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_elem_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_data.out_0[31:ELEM_WIDTH-1] == '0 || out_data.out_0[31:ELEM_WIDTH-1] == '1) &&
      (out_data.out_3[31:ELEM_WIDTH-1] == '0 || out_data.out_3[31:ELEM_WIDTH-1] == '1))
    else $error("result element outside clipped range");

  a_full_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed before acceptance");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for matrix4_row_transform_top: streams left rows through
// the block under randomized valid/ready pressure and checks each result row against
// a built-in Q16.16 predictor. Depends on mrt_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb_top;

  localparam int ELEM_W      = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 12;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  mrt_pkg::left_row_t             in_data;
  logic                           out_valid;
  logic                           out_ready;
  mrt_pkg::result_row_t           out_data;
  logic                           wr_en;
  logic [mrt_pkg::REG_IDX_W-1:0]  wr_index;
  logic [mrt_pkg::REG_DATA_W-1:0] wr_data;

  bit tx_steady;
  bit rx_steady;
  int rx_hold_req;
  int cycle_count;
  int matrices_loaded;

  class row_scoreboard;
    mrt_pkg::right_regs_t right_regs;
    mrt_pkg::result_row_t pending_results[$];
    int                   mismatches;
    int                   rows_checked;
    int                   saturated_rows;

    function new();
      right_regs = '0;
      mismatches = 0;
      rows_checked = 0;
      saturated_rows = 0;
    endfunction

    function logic signed [31:0] elem_of(logic [31:0] v);
      logic signed [31:0] x;
      x = v << (32 - ELEM_W);
      return x >>> (32 - ELEM_W);
    endfunction

    function mrt_pkg::result_row_t transform_row(mrt_pkg::left_row_t row);
      logic signed [31:0]   a[4];
      logic signed [31:0]   col[4];
      logic [63:0]          r;
      logic signed [67:0]   acc;
      logic signed [67:0]   pa;
      logic signed [67:0]   pb;
      logic signed [67:0]   lim_hi;
      logic signed [67:0]   lim_lo;
      mrt_pkg::result_row_t res;
      a[0] = elem_of(row.left_0);
      a[1] = elem_of(row.left_1);
      a[2] = elem_of(row.left_2);
      a[3] = elem_of(row.left_3);
      lim_hi = (68'sd1 <<< (ELEM_W - 1)) - 68'sd1;
      lim_lo = -(68'sd1 <<< (ELEM_W - 1));
      res.saturated = 1'b0;
      for (int j = 0; j < mrt_pkg::NUM_COLS; j++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          r = right_regs[k * 2 + j / 2];
          pa = a[k];
          pb = elem_of((j % 2) ? r[63:32] : r[31:0]);
          acc = acc + pa * pb;
        end
        acc = acc >>> mrt_pkg::FRAC_BITS;
        if (acc > lim_hi) begin
          acc = lim_hi;
          res.saturated = 1'b1;
        end else if (acc < lim_lo) begin
          acc = lim_lo;
          res.saturated = 1'b1;
        end
        col[j] = acc[31:0];
      end
      res.out_0 = col[0];
      res.out_1 = col[1];
      res.out_2 = col[2];
      res.out_3 = col[3];
      return res;
    endfunction

    function void note_request(mrt_pkg::left_row_t row);
      pending_results.push_back(transform_row(row));
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(mrt_pkg::result_row_t got);
      mrt_pkg::result_row_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      rows_checked++;
      if (want.saturated) saturated_rows++;
      check_field("out_0", want.out_0, got.out_0);
      check_field("out_1", want.out_1, got.out_1);
      check_field("out_2", want.out_2, got.out_2);
      check_field("out_3", want.out_3, got.out_3);
      check_field("saturated", 32'(want.saturated), 32'(got.saturated));
    endfunction
  endclass

  row_scoreboard sb;

  matrix4_row_transform_top #(.ELEM_WIDTH(ELEM_W)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // result side: random stalls, long hold-off on request
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        hold = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rst) out_ready = 1'b0;
      else if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else if (rx_steady) out_ready = 1'b1;
      else out_ready = ($urandom_range(99) >= 10);
    end
  end

  function automatic mrt_pkg::left_row_t make_row(logic [31:0] a0, logic [31:0] a1,
                                                  logic [31:0] a2, logic [31:0] a3);
    mrt_pkg::left_row_t r;
    r.left_0 = a0;
    r.left_1 = a1;
    r.left_2 = a2;
    r.left_3 = a3;
    return r;
  endfunction

  function automatic logic [31:0] random_elem(int wide_pct);
    int p;
    p = $urandom_range(99);
    if (p < wide_pct) return $urandom;
    if (p < wide_pct + 10) begin
      case ($urandom_range(6))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        4: return 32'h0000_0001;
        5: return 32'h0001_0000;
        default: return 32'hFFFF_0000;
      endcase
    end
    // within +/-4.0
    return $urandom_range(0, 1 << 19) - (1 << 18);
  endfunction

  function automatic mrt_pkg::left_row_t random_row(int wide_pct);
    return make_row(random_elem(wide_pct), random_elem(wide_pct),
                    random_elem(wide_pct), random_elem(wide_pct));
  endfunction

  function automatic mrt_pkg::right_regs_t put_elem(mrt_pkg::right_regs_t m, int k, int j,
                                                    logic [31:0] v);
    if (j % 2) m[k * 2 + j / 2][63:32] = v;
    else m[k * 2 + j / 2][31:0] = v;
    return m;
  endfunction

  function automatic mrt_pkg::right_regs_t diag_matrix(logic [31:0] d, logic [31:0] off);
    mrt_pkg::right_regs_t m;
    m = '0;
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 4; j++) m = put_elem(m, k, j, (k == j) ? d : off);
    return m;
  endfunction

  function automatic mrt_pkg::right_regs_t column_matrix(logic [31:0] c0, logic [31:0] c1,
                                                         logic [31:0] c2, logic [31:0] c3);
    mrt_pkg::right_regs_t m;
    m = '0;
    for (int k = 0; k < 4; k++) begin
      m = put_elem(m, k, 0, c0);
      m = put_elem(m, k, 1, c1);
      m = put_elem(m, k, 2, c2);
      m = put_elem(m, k, 3, c3);
    end
    return m;
  endfunction

  function automatic mrt_pkg::right_regs_t random_matrix(int wide_pct);
    mrt_pkg::right_regs_t m;
    m = '0;
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 4; j++) m = put_elem(m, k, j, random_elem(wide_pct));
    return m;
  endfunction

  task automatic send_row(input mrt_pkg::left_row_t row);
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = row;
    do @(posedge clk); while (!in_ready);
    if (!tx_steady && $urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 2)) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
  endtask

  task automatic idle_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic load_matrix(input mrt_pkg::right_regs_t m);
    for (int i = 0; i < mrt_pkg::NUM_REGS; i++) begin
      @(negedge clk);
      wr_en    = 1'b1;
      wr_index = mrt_pkg::REG_IDX_W'(i);
      wr_data  = m[i];
      sb.right_regs[i] = m[i];
    end
    @(negedge clk);
    wr_en = 1'b0;
    matrices_loaded++;
  endtask

  task automatic random_phase(int count, int wide_pct);
    for (int n = 0; n < count; n++) send_row(random_row(wide_pct));
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rx_hold_req = 0;
    cycle_count = 0;
    matrices_loaded = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // registers at reset value: all-zero result
    send_row(make_row(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001));
    idle_until_drained();

    load_matrix(diag_matrix(32'h0001_0000, 32'h0));
    send_row(make_row(32'h0, 32'h0, 32'h0, 32'h0));
    send_row(make_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_row(make_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_row(make_row(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001));
    send_row(make_row(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'h8765_4321));
    idle_until_drained();

    // halves: check floor rounding of the shift
    load_matrix(diag_matrix(32'h0000_8000, 32'hFFFF_8000));
    send_row(make_row(32'h1, 32'h0, 32'h0, 32'h0));
    send_row(make_row(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
    send_row(make_row(32'h3, 32'hFFFF_FFFD, 32'h1, 32'hFFFF_FFFF));
    idle_until_drained();

    load_matrix(diag_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_row(make_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_row(make_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_row(make_row(32'h1, 32'h0, 32'h0, 32'h0));
    send_row(make_row(32'h0, 32'h0, 32'h0, 32'h0));
    idle_until_drained();

    // most negative squared: sum needs the full 66 bits
    load_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000));
    send_row(make_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_row(make_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_row(make_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    idle_until_drained();

    load_matrix(column_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFF));
    send_row(make_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_row(make_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_row(make_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    idle_until_drained();

    load_matrix(random_matrix(30));
    random_phase(120, 30);
    idle_until_drained();

    // narrow values, sender pauses mid-stream until all results are back
    load_matrix(random_matrix(0));
    random_phase(60, 5);
    idle_until_drained();
    random_phase(60, 5);
    idle_until_drained();

    // hold off the result side so the pipeline fills, then run with no idling
    load_matrix(random_matrix(20));
    tx_steady = 1'b1;
    @(posedge clk);
    rx_hold_req = 80;
    random_phase(40, 20);
    rx_steady = 1'b1;
    random_phase(60, 20);
    rx_steady = 1'b0;
    tx_steady = 1'b0;
    idle_until_drained();

    load_matrix(random_matrix(100));
    random_phase(100, 100);
    idle_until_drained();

    load_matrix(random_matrix(50));
    random_phase(100, 50);
    idle_until_drained();

    $display("%0d result rows checked, %0d saturated, across %0d right matrices",
             sb.rows_checked, sb.saturated_rows, matrices_loaded);
    $display("covered floor rounding, both saturation directions and backpressure");
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
